// ----- sv/grfa_pkg.sv -----
package grfa_pkg;

  // Default sizes of the grid store
  localparam int DEF_MAX_COLUMNS = 16;
  localparam int DEF_MAX_ROWS    = 16;
  localparam int DEF_ID_BITS     = 8;

  // Fixed field widths of the request and result channels
  localparam int ID_FIELD_W  = 8;
  localparam int SIZE_W      = 5;
  localparam int SLOT_W      = 8;
  localparam int COUNT_W     = 9;
  localparam int REG_W       = 5;
  localparam int CFG_INDEX_W = 1;

  // Configuration register indexes and reset values
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS    = 1'b1;
  localparam logic [REG_W-1:0]       GRID_COLUMNS_RESET = 5'd8;
  localparam logic [REG_W-1:0]       GRID_ROWS_RESET    = 5'd8;

  // Request kinds
  localparam logic KIND_PLACE  = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLACE_POS,
    ST_PLACE_READ,
    ST_PLACE_CHECK,
    ST_PLACE_FILL,
    ST_REMOVE_READ,
    ST_REMOVE_CHECK,
    ST_DONE
  } grfa_state_t;

  typedef struct packed {
    logic                  kind;
    logic [ID_FIELD_W-1:0] item_id;
    logic [SIZE_W-1:0]     item_width;
    logic [SIZE_W-1:0]     item_height;
  } grfa_request_t;

  typedef struct packed {
    logic               placed;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] cells_cleared;
  } grfa_result_t;

endpackage

// ----- sv/grfa_if.sv -----
// Request channel: one place or remove request
interface grfa_req_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [grfa_pkg::ID_FIELD_W-1:0] item_id;
  logic [grfa_pkg::SIZE_W-1:0]     item_width;
  logic [grfa_pkg::SIZE_W-1:0]     item_height;

  modport source (output valid, kind, item_id, item_width, item_height, input ready);
  modport sink   (input valid, kind, item_id, item_width, item_height, output ready);
endinterface

// Result channel: one result per request
interface grfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         placed;
  logic [grfa_pkg::SLOT_W-1:0]  slot_index;
  logic [grfa_pkg::COUNT_W-1:0] cells_cleared;

  modport source (output valid, placed, slot_index, cells_cleared, input ready);
  modport sink   (input valid, placed, slot_index, cells_cleared, output ready);
endinterface

// ----- sv/grfa_engine.sv -----
module grfa_engine #(
  parameter int MAX_COLUMNS = grfa_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = grfa_pkg::DEF_MAX_ROWS,
  parameter int ID_BITS     = grfa_pkg::DEF_ID_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  grfa_pkg::grfa_request_t           request,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]  cols,
  input  logic [$clog2(MAX_ROWS+1)-1:0]     rows,
  output logic                              idle,
  output logic                              res_valid,
  input  logic                              res_take,
  output grfa_pkg::grfa_result_t            result
);
  import grfa_pkg::*;

  localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int XW     = $clog2(MAX_COLUMNS + 1);
  localparam int YW     = $clog2(MAX_ROWS + 1);
  localparam int PW     = XW + YW;
  localparam int CMP_W  =
    $clog2(((MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS) + 32) + 1;
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

  grfa_state_t state, state_next;

  logic [XW-1:0]      cx, cx_next;
  logic [YW-1:0]      cy, cy_next;
  logic [SIZE_W-1:0]  ox, ox_next;
  logic [SIZE_W-1:0]  oy, oy_next;
  logic [ID_BITS-1:0] id, id_next;
  logic [SIZE_W-1:0]  w, w_next;
  logic [SIZE_W-1:0]  h, h_next;
  logic [ADDR_W-1:0]  clr_addr, clr_addr_next;
  logic [COUNT_W-1:0] cleared, cleared_next;
  grfa_result_t       res, res_next;

  // Grid store and its port
  logic [ID_BITS-1:0] grid [CELLS];
  logic [ID_BITS-1:0] rd_data;
  logic               mem_we;
  logic               mem_re;
  logic [ID_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_addr;

  // Shared address unit: (cy + oy) * cols + (cx + ox)
  logic [YW-1:0]      a_row;
  logic [XW-1:0]      a_col;
  logic [PW-1:0]      a_full;
  logic [ID_BITS-1:0] req_id;

  assign a_row  = cy + YW'(oy);
  assign a_col  = cx + XW'(ox);
  assign a_full = PW'(a_row) * PW'(cols) + PW'(a_col);
  assign req_id = ID_BITS'(request.item_id);

  assign mem_addr = (state == ST_CLEAR) ? clr_addr : ADDR_W'(a_full);

  always_ff @(posedge clk) begin
    if (mem_we) grid[mem_addr] <= mem_wdata;
    if (mem_re) rd_data <= grid[mem_addr];
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
    cx      <= cx_next;
    cy      <= cy_next;
    ox      <= ox_next;
    oy      <= oy_next;
    id      <= id_next;
    w       <= w_next;
    h       <= h_next;
    cleared <= cleared_next;
    res     <= res_next;
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    cx_next       = cx;
    cy_next       = cy;
    ox_next       = ox;
    oy_next       = oy;
    id_next       = id;
    w_next        = w;
    h_next        = h;
    clr_addr_next = clr_addr;
    cleared_next  = cleared;
    res_next      = res;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wdata     = '0;
    idle          = 1'b0;
    res_valid     = 1'b0;

    unique case (state)
      // sweep the grid to zero after reset
      ST_CLEAR: begin
        mem_we        = 1'b1;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          id_next      = req_id;
          w_next       = request.item_width;
          h_next       = request.item_height;
          cx_next      = '0;
          cy_next      = '0;
          ox_next      = '0;
          oy_next      = '0;
          cleared_next = '0;
          res_next     = '0;
          if (request.kind == KIND_REMOVE) begin
            if (req_id == '0 || cols == '0 || rows == '0) state_next = ST_DONE;
            else state_next = ST_REMOVE_READ;
          end else begin
            if (req_id == '0 || request.item_width == '0 || request.item_height == '0 ||
                cols == '0 || rows == '0) state_next = ST_DONE;
            else state_next = ST_PLACE_POS;
          end
        end
      end

      // bounds of the candidate top-left cell
      ST_PLACE_POS: begin
        ox_next = '0;
        oy_next = '0;
        if (CMP_W'(cy) + CMP_W'(h) > CMP_W'(rows)) begin
          res_next   = '0;
          state_next = ST_DONE;
        end else if (CMP_W'(cx) + CMP_W'(w) > CMP_W'(cols)) begin
          cx_next = '0;
          cy_next = cy + YW'(1);
        end else begin
          state_next = ST_PLACE_READ;
        end
      end

      ST_PLACE_READ: begin
        mem_re     = 1'b1;
        state_next = ST_PLACE_CHECK;
      end

      // a busy cell rules out every candidate up to its column on this row
      ST_PLACE_CHECK: begin
        if (rd_data != '0) begin
          cx_next    = a_col + XW'(1);
          state_next = ST_PLACE_POS;
        end else if (ox + SIZE_W'(1) != w) begin
          ox_next    = ox + SIZE_W'(1);
          state_next = ST_PLACE_READ;
        end else if (oy + SIZE_W'(1) != h) begin
          ox_next    = '0;
          oy_next    = oy + SIZE_W'(1);
          state_next = ST_PLACE_READ;
        end else begin
          ox_next    = '0;
          oy_next    = '0;
          state_next = ST_PLACE_FILL;
        end
      end

      // write the id over the rectangle, one cell a cycle
      ST_PLACE_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = id;
        if (ox == '0 && oy == '0) begin
          res_next.slot_index = SLOT_W'(a_full);
        end
        if (ox + SIZE_W'(1) != w) begin
          ox_next = ox + SIZE_W'(1);
        end else begin
          ox_next = '0;
          if (oy + SIZE_W'(1) != h) begin
            oy_next = oy + SIZE_W'(1);
          end else begin
            res_next.placed = 1'b1;
            state_next      = ST_DONE;
          end
        end
      end

      ST_REMOVE_READ: begin
        mem_re     = 1'b1;
        state_next = ST_REMOVE_CHECK;
      end

      // free a matching cell and step through the grid in row-major order
      ST_REMOVE_CHECK: begin
        if (rd_data == id) begin
          mem_we       = 1'b1;
          cleared_next = cleared + COUNT_W'(1);
        end
        state_next = ST_REMOVE_READ;
        if (cx + XW'(1) == cols) begin
          cx_next = '0;
          if (cy + YW'(1) == rows) begin
            state_next = ST_DONE;
          end else begin
            cy_next = cy + YW'(1);
          end
        end else begin
          cx_next = cx + XW'(1);
        end
        res_next.cells_cleared = cleared_next;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) state_next = ST_IDLE;
      end

      default: state_next = ST_CLEAR;
    endcase
  end

  assign result = res;

endmodule

// ----- sv/grid_rectangle_first_fit_allocator.sv -----
// Channel  Dir  Payload                                         Handshake
// req      in   kind, item_id, item_width, item_height          valid/ready
// rsp      out  placed, slot_index, cells_cleared               valid/ready
// cfg      in   cfg_index (0 columns, 1 rows), cfg_data         cfg_we only
//
// After reset the grid store is swept to zero, all MAX_COLUMNS * MAX_ROWS cells
// (256 by default), and req.ready stays low meanwhile.
// One request at a time; cost is set by the single-port grid store and the
// shared address multiplier: a place reads each cell checked, steps through the
// candidates and then writes width * height cells; a remove reads all columns *
// rows cells; a rejected request goes straight to its result. A result waits in
// the output register while the next request is taken; the engine stalls only
// if that register is full.
module grid_rectangle_first_fit_allocator #(
  parameter int MAX_COLUMNS = grfa_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = grfa_pkg::DEF_MAX_ROWS,
  parameter int ID_BITS     = grfa_pkg::DEF_ID_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  grfa_req_if.sink                         req,
  grfa_rsp_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [grfa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [grfa_pkg::REG_W-1:0]       cfg_data
);
  import grfa_pkg::*;

  localparam int XW = $clog2(MAX_COLUMNS + 1);
  localparam int YW = $clog2(MAX_ROWS + 1);

  logic [REG_W-1:0] grid_columns;
  logic [REG_W-1:0] grid_rows;
  logic [XW-1:0]    cols;
  logic [YW-1:0]    rows;

  grfa_request_t request;
  grfa_result_t  eng_result;
  grfa_result_t  out_res;
  logic          eng_idle;
  logic          eng_valid;
  logic          eng_take;
  logic          out_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= GRID_COLUMNS_RESET;
      grid_rows    <= GRID_ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_COLUMNS: grid_columns <= cfg_data;
        REG_GRID_ROWS:    grid_rows    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shape in use, saturated to the store size
  assign cols = (32'(grid_columns) > MAX_COLUMNS) ? XW'(MAX_COLUMNS) : XW'(grid_columns);
  assign rows = (32'(grid_rows) > MAX_ROWS) ? YW'(MAX_ROWS) : YW'(grid_rows);

  assign request.kind        = req.kind;
  assign request.item_id     = req.item_id;
  assign request.item_width  = req.item_width;
  assign request.item_height = req.item_height;
  assign req.ready           = eng_idle;

  grfa_engine #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .ID_BITS     (ID_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (req.valid && eng_idle),
    .request   (request),
    .cols      (cols),
    .rows      (rows),
    .idle      (eng_idle),
    .res_valid (eng_valid),
    .res_take  (eng_take),
    .result    (eng_result)
  );

  // Output register
  assign eng_take = eng_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (eng_take) out_res <= eng_result;
  end

  assign rsp.valid         = out_valid;
  assign rsp.placed        = out_res.placed;
  assign rsp.slot_index    = out_res.slot_index;
  assign rsp.cells_cleared = out_res.cells_cleared;

endmodule

// ----- bench/tb_grid_rectangle_first_fit_allocator.sv -----
module tb_grid_rectangle_first_fit_allocator;
  import grfa_pkg::*;

  localparam int GRID_MAX_COLS = DEF_MAX_COLUMNS;
  localparam int GRID_MAX_ROWS = DEF_MAX_ROWS;
  localparam int GRID_CELLS    = GRID_MAX_COLS * GRID_MAX_ROWS;
  localparam int GRID_AW       = $clog2(GRID_CELLS);

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [REG_W-1:0]       cfg_data;

  grfa_req_if request_bus ();
  grfa_rsp_if result_bus ();

  grid_rectangle_first_fit_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (request_bus),
    .rsp       (result_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the grid and its shape
  logic [ID_FIELD_W-1:0] shadow_grid [GRID_CELLS];
  logic [REG_W-1:0]      shadow_columns;
  logic [REG_W-1:0]      shadow_rows;

  grfa_result_t          expected_outcomes [$];
  logic [ID_FIELD_W-1:0] live_ids [$];
  int                    fail_count = 0;
  int                    burst_left;
  logic [15:0]           rsp_cycle;
  logic [15:0]           ready_pattern;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the outcome of one request and updates the shadow grid
  function automatic grfa_result_t allocate_or_free(input grfa_request_t r);
    int           cols, rows, total, wid, hgt, i, cx, cy, x, y;
    bit           fits;
    grfa_result_t res;
    res  = '0;
    cols = (shadow_columns > GRID_MAX_COLS) ? GRID_MAX_COLS : int'(shadow_columns);
    rows = (shadow_rows > GRID_MAX_ROWS) ? GRID_MAX_ROWS : int'(shadow_rows);
    total = cols * rows;
    wid  = int'(r.item_width);
    hgt  = int'(r.item_height);
    if (r.kind == KIND_REMOVE) begin
      if (r.item_id != '0) begin
        for (i = 0; i < total; i++) begin
          if (shadow_grid[GRID_AW'(i)] == r.item_id) begin
            shadow_grid[GRID_AW'(i)] = '0;
            res.cells_cleared        = res.cells_cleared + 1'b1;
          end
        end
      end
    end else if (r.item_id != '0 && wid != 0 && hgt != 0 && total != 0) begin
      for (i = 0; i < total && !res.placed; i++) begin
        x = i % cols;
        y = i / cols;
        if (x + wid <= cols && y + hgt <= rows) begin
          fits = 1'b1;
          for (cy = 0; cy < hgt; cy++)
            for (cx = 0; cx < wid; cx++)
              if (shadow_grid[GRID_AW'((y + cy) * cols + x + cx)] != '0) fits = 1'b0;
          if (fits) begin
            for (cy = 0; cy < hgt; cy++)
              for (cx = 0; cx < wid; cx++)
                shadow_grid[GRID_AW'((y + cy) * cols + x + cx)] = r.item_id;
            res.placed     = 1'b1;
            res.slot_index = i[SLOT_W-1:0];
          end
        end
      end
    end
    return res;
  endfunction

  // Offers one request, records its outcome once taken, then maybe pauses
  task automatic send_request(input logic kind, input logic [ID_FIELD_W-1:0] id,
                              input logic [SIZE_W-1:0] wid, input logic [SIZE_W-1:0] hgt);
    grfa_request_t r;
    r.kind        = kind;
    r.item_id     = id;
    r.item_width  = wid;
    r.item_height = hgt;
    request_bus.valid       <= 1'b1;
    request_bus.kind        <= kind;
    request_bus.item_id     <= id;
    request_bus.item_width  <= wid;
    request_bus.item_height <= hgt;
    @(posedge clk);
    while (!request_bus.ready) @(posedge clk);
    expected_outcomes.push_back(allocate_or_free(r));
    burst_left--;
    if (burst_left <= 0) begin
      request_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // Reshapes the grid once all outstanding requests have come back
  task automatic set_grid(input logic [REG_W-1:0] cols, input logic [REG_W-1:0] rows);
    request_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk);
    shadow_columns = cols;
    cfg_index <= REG_GRID_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    shadow_rows = rows;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result check and receiver stall pattern
  always @(posedge clk) begin
    grfa_result_t want;
    if (rst) begin
      result_bus.ready <= 1'b0;
      rsp_cycle        <= '0;
      ready_pattern    <= 16'hB7CE;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t unexpected result: placed %0d slot %0d cleared %0d", $time,
                   result_bus.placed, result_bus.slot_index, result_bus.cells_cleared);
          fail_count++;
        end else begin
          want = expected_outcomes.pop_front();
          if (result_bus.placed !== want.placed) begin
            $display("%0t placed mismatch: expected %0d actual %0d", $time,
                     want.placed, result_bus.placed);
            fail_count++;
          end
          if (result_bus.slot_index !== want.slot_index) begin
            $display("%0t slot_index mismatch: expected %0d actual %0d", $time,
                     want.slot_index, result_bus.slot_index);
            fail_count++;
          end
          if (result_bus.cells_cleared !== want.cells_cleared) begin
            $display("%0t cells_cleared mismatch: expected %0d actual %0d", $time,
                     want.cells_cleared, result_bus.cells_cleared);
            fail_count++;
          end
        end
      end
      rsp_cycle     <= rsp_cycle + 1'b1;
      ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
      case (rsp_cycle[10:9])
        2'd0:    result_bus.ready <= 1'b1;
        2'd1:    result_bus.ready <= ($urandom_range(0, 3) != 0);
        2'd2:    result_bus.ready <= ready_pattern[15];
        default: result_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Default 8x8 grid: bad sizes, null id, full grid, remove and re-place
  task automatic test_default_grid();
    send_request(KIND_PLACE, 1, 1, 1);
    send_request(KIND_PLACE, 255, 8, 8);
    send_request(KIND_PLACE, 2, 0, 1);
    send_request(KIND_PLACE, 3, 1, 0);
    send_request(KIND_PLACE, 0, 2, 2);
    send_request(KIND_PLACE, 4, 31, 31);
    send_request(KIND_PLACE, 5, 16, 1);
    send_request(KIND_PLACE, 6, 7, 1);
    send_request(KIND_PLACE, 170, 8, 7);
    send_request(KIND_PLACE, 8, 1, 1);
    send_request(KIND_REMOVE, 0, 0, 0);
    send_request(KIND_REMOVE, 170, 0, 0);
    send_request(KIND_REMOVE, 200, 0, 0);
    send_request(KIND_PLACE, 85, 8, 7);
    send_request(KIND_REMOVE, 1, 31, 31);
    send_request(KIND_PLACE, 16, 1, 1);
  endtask

  // Shape changes: old cells kept, empty grid, saturated registers
  task automatic test_grid_shapes();
    set_grid(16, 16);
    send_request(KIND_PLACE, 9, 16, 16);
    send_request(KIND_PLACE, 10, 16, 1);
    set_grid(0, 8);
    send_request(KIND_PLACE, 11, 1, 1);
    send_request(KIND_REMOVE, 6, 0, 0);
    set_grid(8, 0);
    send_request(KIND_PLACE, 11, 1, 1);
    set_grid(31, 31);
    send_request(KIND_PLACE, 12, 2, 2);
    send_request(KIND_REMOVE, 85, 0, 0);
    set_grid(1, 1);
    send_request(KIND_PLACE, 13, 1, 1);
    send_request(KIND_REMOVE, 13, 0, 0);
    set_grid(17, 1);
    send_request(KIND_PLACE, 14, 16, 1);
  endtask

  // Phases of random traffic, each on a freshly chosen grid shape
  task automatic test_random_traffic();
    int                    phase, n, sel, pick, cols;
    logic [ID_FIELD_W-1:0] id;
    logic [SIZE_W-1:0]     wid, hgt;
    for (phase = 0; phase < 10; phase++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       set_grid(16, 16);
        1:       set_grid(1, REG_W'($urandom_range(1, 16)));
        2:       set_grid(REG_W'($urandom_range(0, 31)), REG_W'($urandom_range(0, 31)));
        default: set_grid(REG_W'($urandom_range(1, 16)), REG_W'($urandom_range(1, 16)));
      endcase
      cols = (shadow_columns == 0 || shadow_columns > 16) ? 16 : int'(shadow_columns);
      for (n = 0; n < 50; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          id  = ID_FIELD_W'($urandom_range(1, 255));
          wid = SIZE_W'(($urandom_range(0, 5) == 0) ? $urandom_range(1, cols)
                                                   : $urandom_range(1, 4));
          hgt = SIZE_W'(($urandom_range(0, 5) == 0) ? $urandom_range(1, 16)
                                                   : $urandom_range(1, 4));
          live_ids.push_back(id);
          send_request(KIND_PLACE, id, wid, hgt);
        end else if (pick < 90) begin
          if (live_ids.size() != 0) begin
            sel = $urandom_range(0, live_ids.size() - 1);
            id  = live_ids[sel];
            live_ids.delete(sel);
          end else begin
            id = ID_FIELD_W'($urandom_range(1, 255));
          end
          send_request(KIND_REMOVE, id, SIZE_W'($urandom_range(0, 31)),
                       SIZE_W'($urandom_range(0, 31)));
        end else begin
          // noise over the whole field range
          send_request(1'($urandom_range(0, 1)), ID_FIELD_W'($urandom_range(0, 255)),
                       SIZE_W'($urandom_range(0, 31)), SIZE_W'($urandom_range(0, 31)));
        end
      end
    end
  endtask

  initial begin
    clk                     = 1'b0;
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = REG_GRID_COLUMNS;
    cfg_data                = '0;
    request_bus.valid       = 1'b0;
    request_bus.kind        = KIND_PLACE;
    request_bus.item_id     = '0;
    request_bus.item_width  = '0;
    request_bus.item_height = '0;
    burst_left              = 4;
    for (int i = 0; i < GRID_CELLS; i++) shadow_grid[GRID_AW'(i)] = '0;
    shadow_columns = GRID_COLUMNS_RESET;
    shadow_rows    = GRID_ROWS_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_default_grid();
    test_grid_shapes();
    test_random_traffic();

    // drain, then watch for stray results
    request_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, well above the slowest legal run
  initial begin
    #300_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/grfa_pkg.sv
sv/grfa_if.sv
sv/grfa_engine.sv
sv/grid_rectangle_first_fit_allocator.sv
bench/tb_grid_rectangle_first_fit_allocator.sv
